@@ hw/rtl/eds_pkg.sv @@
// Shared types and constants for the event deadline scheduler.
// Used by eds_slot_file, eds_min_scan, event_deadline_scheduler, eds_checker and tb; no dependencies.
`default_nettype none

package eds_pkg;

   localparam int NUM_EVENTS = 8;
   localparam int IDX_W      = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int EV_W       = 4;
   localparam int TIME_W     = 64;
   localparam int AMT_W      = 32;
   localparam int DELTA_W    = 31;

   localparam logic [EV_W:0]      EV_LIMIT  = (EV_W + 1)'(NUM_EVENTS);
   localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

   // request codes; unused codes behave as status only
   localparam logic [2:0] REQ_ADVANCE  = 3'd0;
   localparam logic [2:0] REQ_SCHEDULE = 3'd1;
   localparam logic [2:0] REQ_CANCEL   = 3'd2;
   localparam logic [2:0] REQ_POP      = 3'd3;
   localparam logic [2:0] REQ_STATUS   = 3'd4;

   typedef struct packed {
      logic [2:0]             req_type;
      logic [EV_W-1:0]        event_type;
      logic signed [AMT_W-1:0] amount;
   } eds_req_type;

   typedef struct packed {
      logic               popped_valid;
      logic [EV_W-1:0]    popped_event;
      logic               type_pending;
      logic               any_pending;
      logic [DELTA_W-1:0] next_delta;
   } eds_rsp_type;

   // slot write command: set loads a deadline and marks active, else clears active
   typedef struct packed {
      logic              en;
      logic              set;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] deadline;
   } slot_wr_type;

   // minimum search result, held until the next start
   typedef struct packed {
      logic              done;
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] when;
   } scan_res_type;

endpackage

`default_nettype wire

@@ hw/rtl/event_deadline_scheduler.sv @@
// Event deadline scheduler: a 64-bit signed time counter plus one deadline slot per
// event type. Each request transaction advances time, schedules, cancels, pops the
// earliest expired event, or only reports status, and yields exactly one response
// transaction describing the state after the request. One request is handled at a
// time: req_stall is high from acceptance until the response is loaded into the
// output register. The cost is set by the earliest-deadline scan, which visits one
// slot per cycle; a pop scans before and after removing the event, and any other
// request scans once. A new request is taken while the previous response still
// waits on rsp_stall. No clearing pass is needed after reset.
// Depends on eds_pkg, eds_slot_file and eds_min_scan.
`default_nettype none

module event_deadline_scheduler (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire eds_pkg::eds_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output eds_pkg::eds_rsp_type      rsp_data
);
   import eds_pkg::*;

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EXEC   = 4'd1;
   localparam logic [3:0] ST_SCAN_A = 4'd2;  // search before a pop
   localparam logic [3:0] ST_WAIT_A = 4'd3;
   localparam logic [3:0] ST_POP    = 4'd4;
   localparam logic [3:0] ST_SCAN_B = 4'd5;  // search for the reported state
   localparam logic [3:0] ST_WAIT_B = 4'd6;
   localparam logic [3:0] ST_DELTA  = 4'd7;
   localparam logic [3:0] ST_RESULT = 4'd8;

   logic [3:0]        state_ff, state_in;
   eds_req_type       req_ff;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              pv_ff, pv_in;
   logic [EV_W-1:0]   pe_ff, pe_in;
   logic [TIME_W-1:0] diff_ff;
   logic              later_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   eds_rsp_type       rsp_ff, rsp_in;

   logic              req_fire;
   logic              rsp_free;
   logic              in_range;
   logic [IDX_W-1:0]  ev_idx;
   logic [TIME_W-1:0] now_plus_amt;
   logic              pop_fire;
   logic              scan_start;
   slot_wr_type       slot_wr;
   logic [IDX_W-1:0]  scan_idx;
   logic [TIME_W-1:0] scan_deadline;
   logic [NUM_EVENTS-1:0] slot_active;
   scan_res_type      scan_res;
   logic [DELTA_W-1:0] delta;

   // ---------------------------------------------------------------- handshakes
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   // the output register can take a new response when empty or being drained
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------- request decode
   assign in_range     = ({1'b0, req_ff.event_type} < EV_LIMIT);
   assign ev_idx       = req_ff.event_type[IDX_W-1:0];
   // one 64-bit adder serves both advance and schedule
   assign now_plus_amt = now_ff + TIME_W'(req_ff.amount);
   // pop only when the earliest active deadline is not after now
   assign pop_fire     = scan_res.found && !($signed(now_ff) < $signed(scan_res.when));
   assign scan_start   = (state_ff == ST_SCAN_A) || (state_ff == ST_SCAN_B);

   // ---------------------------------------------------------------- slot writes
   always_comb begin
      slot_wr          = '0;
      slot_wr.deadline = now_plus_amt;
      slot_wr.idx      = ev_idx;
      if (state_ff == ST_EXEC && in_range) begin
         if (req_ff.req_type == REQ_SCHEDULE) begin
            slot_wr.en  = 1'b1;
            slot_wr.set = 1'b1;
         end else if (req_ff.req_type == REQ_CANCEL) begin
            slot_wr.en  = 1'b1;
         end
      end else if (state_ff == ST_POP && pop_fire) begin
         // retire the earliest slot
         slot_wr.en  = 1'b1;
         slot_wr.idx = scan_res.idx;
      end
   end

   eds_slot_file u_slots (
      .clock       (clock),
      .reset       (reset),
      .wr          (slot_wr),
      .rd_idx      (scan_idx),
      .rd_deadline (scan_deadline),
      .active      (slot_active)
   );

   eds_min_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .active      (slot_active),
      .rd_deadline (scan_deadline),
      .rd_idx      (scan_idx),
      .res         (scan_res)
   );

   // ---------------------------------------------------------------- next_delta
   // Clamp the registered difference: nothing pending gives the maximum, a due
   // deadline gives zero, anything beyond 31 bits saturates.
   always_comb begin
      if (!scan_res.found) begin
         delta = DELTA_MAX;
      end else if (!later_ff) begin
         delta = '0;
      end else if (diff_ff[TIME_W-1:DELTA_W] != '0) begin
         delta = DELTA_MAX;
      end else begin
         delta = diff_ff[DELTA_W-1:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      pv_in        = pv_ff;
      pe_in        = pe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pv_in    = 1'b0;
               pe_in    = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (req_ff.req_type == REQ_ADVANCE) begin
               now_in = now_plus_amt;
            end
            state_in = (req_ff.req_type == REQ_POP) ? ST_SCAN_A : ST_SCAN_B;
         end
         ST_SCAN_A: state_in = ST_WAIT_A;
         ST_WAIT_A: begin
            if (scan_res.done) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (pop_fire) begin
               now_in = scan_res.when;
               pv_in  = 1'b1;
               pe_in  = EV_W'(scan_res.idx);
            end
            state_in = ST_SCAN_B;
         end
         ST_SCAN_B: state_in = ST_WAIT_B;
         ST_WAIT_B: begin
            if (scan_res.done) begin
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: state_in = ST_RESULT;
         ST_RESULT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.popped_valid = pv_ff;
               rsp_in.popped_event = pe_ff;
               rsp_in.type_pending = in_range && slot_active[ev_idx];
               rsp_in.any_pending  = scan_res.found;
               rsp_in.next_delta   = delta;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      pv_ff    <= pv_in;
      pe_ff    <= pe_in;
      diff_ff  <= scan_res.when - now_ff;
      later_ff <= $signed(now_ff) < $signed(scan_res.when);
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // a response appears only as the sequencer leaves its result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_RESULT)
      else $error("response raised outside the result state");

   // the search only completes while the sequencer waits for it
   a_scan_done_wait: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == ST_WAIT_A || state_ff == ST_WAIT_B))
      else $error("scan finished while sequencer not waiting");

   // a pop moves time to the popped deadline
   a_pop_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && pop_fire) |=> now_ff == $past(scan_res.when))
      else $error("pop did not move time to the deadline");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/eds_slot_file.sv @@
// Event slot storage: active flags and absolute deadlines.
// Depends on eds_pkg.
`default_nettype none

module eds_slot_file (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire eds_pkg::slot_wr_type            wr,
   input  wire logic [eds_pkg::IDX_W-1:0]       rd_idx,
   output logic [eds_pkg::TIME_W-1:0]           rd_deadline,
   output logic [eds_pkg::NUM_EVENTS-1:0]       active
);
   import eds_pkg::*;

   logic [NUM_EVENTS-1:0] active_ff;
   logic [NUM_EVENTS-1:0] active_in;
   logic [TIME_W-1:0]     deadline_ff [NUM_EVENTS];

   always_comb begin
      active_in = active_ff;
      if (wr.en) begin
         active_in[wr.idx] = wr.set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // deadlines are only read where the slot is active
   always_ff @(posedge clock) begin
      if (wr.en && wr.set) begin
         deadline_ff[wr.idx] <= wr.deadline;
      end
   end

   assign rd_deadline = deadline_ff[rd_idx];
   assign active      = active_ff;

endmodule

`default_nettype wire

@@ hw/rtl/eds_min_scan.sv @@
// Iterative earliest-deadline search: one slot and one signed compare per cycle.
// Depends on eds_pkg; reads slots through eds_slot_file.
`default_nettype none

module eds_min_scan (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [eds_pkg::NUM_EVENTS-1:0]  active,
   input  wire logic [eds_pkg::TIME_W-1:0]      rd_deadline,
   output logic [eds_pkg::IDX_W-1:0]            rd_idx,
   output eds_pkg::scan_res_type                res
);
   import eds_pkg::*;

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [IDX_W-1:0]  cnt_ff,   cnt_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_ff,  best_in;
   logic [TIME_W-1:0] when_ff,  when_in;
   logic              take;
   logic              last;

   assign take = active[cnt_ff] &&
                 (!found_ff || ($signed(rd_deadline) < $signed(when_ff)));
   assign last = (cnt_ff == IDX_W'(NUM_EVENTS - 1));

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      found_in = found_ff;
      best_in  = best_ff;
      when_in  = when_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         found_in = 1'b0;
         best_in  = '0;
      end else if (busy_ff) begin
         if (take) begin
            found_in = 1'b1;
            best_in  = cnt_ff;
            when_in  = rd_deadline;
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      when_ff <= when_in;
   end

   assign rd_idx    = cnt_ff;
   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.idx   = best_ff;
   assign res.when  = when_ff;

endmodule

`default_nettype wire

@@ bench/eds_checker.sv @@
// Scoreboard for the event deadline scheduler: keeps its own time counter and deadline slots,
// predicts one response per accepted request and compares it with each accepted response.
// Depends on eds_pkg only.
module eds_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire eds_pkg::eds_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire eds_pkg::eds_rsp_type rsp_data,
   output int                        fail_count,
   output int                        outstanding
);
   import eds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   longint      sim_now;
   bit          slot_live [NUM_EVENTS];
   longint      slot_due  [NUM_EVENTS];
   eds_rsp_type expected_rsp_q[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // earliest live slot by signed deadline, lowest index on a tie
   function automatic bit find_earliest(output int unsigned idx, output longint due);
      bit found;
      found = 1'b0;
      idx   = 0;
      due   = 0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         if (slot_live[i] && (!found || slot_due[i] < due)) begin
            found = 1'b1;
            idx   = i;
            due   = slot_due[i];
         end
      end
      return found;
   endfunction

   function automatic eds_rsp_type predict_response(input eds_req_type r);
      eds_rsp_type rsp;
      bit          in_range;
      bit          found;
      int unsigned idx;
      longint      due;
      logic [63:0] ahead;
      rsp      = '0;
      in_range = r.event_type < NUM_EVENTS;
      case (r.req_type)
         REQ_ADVANCE: begin
            sim_now += longint'(signed'(r.amount));
         end
         REQ_SCHEDULE: begin
            if (in_range) begin
               slot_live[r.event_type] = 1'b1;
               slot_due[r.event_type]  = sim_now + longint'(signed'(r.amount));
            end
         end
         REQ_CANCEL: begin
            if (in_range) slot_live[r.event_type] = 1'b0;
         end
         REQ_POP: begin
            found = find_earliest(idx, due);
            if (found && !(sim_now < due)) begin
               slot_live[idx]   = 1'b0;
               sim_now          = due;
               rsp.popped_valid = 1'b1;
               rsp.popped_event = EV_W'(idx);
            end
         end
         default: ;   // status and spare codes change nothing
      endcase
      found            = find_earliest(idx, due);
      rsp.any_pending  = found;
      rsp.type_pending = in_range && slot_live[r.event_type];
      if (!found) begin
         rsp.next_delta = DELTA_MAX;
      end else if (!(sim_now < due)) begin
         rsp.next_delta = '0;
      end else begin
         ahead = due - sim_now;
         rsp.next_delta = (ahead > 64'(DELTA_MAX)) ? DELTA_MAX : ahead[DELTA_W-1:0];
      end
      return rsp;
   endfunction

   function automatic int field_differs(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      int          bad;
      eds_rsp_type want;
      bad = 0;
      if (reset) begin
         sim_now = 0;
         for (int i = 0; i < NUM_EVENTS; i++) begin
            slot_live[i] = 1'b0;
            slot_due[i]  = 0;
         end
         expected_rsp_q.delete();
      end else begin
         if (req_valid && !req_stall) expected_rsp_q.push_back(predict_response(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               bad++;
            end else begin
               want = expected_rsp_q.pop_front();
               bad += field_differs("popped_valid", want.popped_valid, rsp_data.popped_valid);
               bad += field_differs("popped_event", want.popped_event, rsp_data.popped_event);
               bad += field_differs("type_pending", want.type_pending, rsp_data.type_pending);
               bad += field_differs("any_pending", want.any_pending, rsp_data.any_pending);
               bad += field_differs("next_delta", want.next_delta, rsp_data.next_delta);
            end
         end
      end
      fail_count  <= fail_count + bad;
      outstanding <= expected_rsp_q.size();
   end

endmodule

@@ bench/tb.sv @@
// Top of the event deadline scheduler testbench: clock, reset, request stimulus, response
// stall pattern, watchdog and verdict. Depends on eds_pkg, eds_checker and the scheduler RTL.
module tb;
   import eds_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int POP_LATENCY    = 2 * NUM_EVENTS + 8;
   localparam int WATCHDOG_LIMIT = 5000;

   // request codes the block treats as status only
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   localparam logic signed [AMT_W-1:0] AMT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [AMT_W-1:0] AMT_MIN = 32'sh8000_0000;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   eds_req_type req_data  = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   eds_rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int idle_cycles = 0;
   bit quiet = 1'b0;   // while set, neither side idles
   int stall_left = 0;
   int flow_left  = 0;

   always #CLK_HALF clock = ~clock;

   event_deadline_scheduler i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   eds_checker i_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .fail_count,
      .outstanding
   );

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   // Response side: alternate free-flowing runs with stalls of random length.
   always @(posedge clock) begin
      if (stall_left > 0 && !quiet) begin
         rsp_stall  <= 1'b1;
         stall_left -= 1;
      end else if (flow_left > 0) begin
         rsp_stall <= 1'b0;
         flow_left -= 1;
      end else begin
         rsp_stall  <= 1'b0;
         flow_left  = $urandom_range(6);
         stall_left = pick_gap();
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Present one request after a random gap and hold it until accepted.
   task automatic send_op(input logic [2:0] code, input logic [EV_W-1:0] slot,
                          input logic signed [AMT_W-1:0] amt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.req_type   <= code;
      req_data.event_type <= slot;
      req_data.amount     <= amt;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every expected response has come back.
   task automatic wait_responses_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [2:0]              code;
      logic [EV_W-1:0]         slot;
      logic signed [AMT_W-1:0] amt;
      int                      roll;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_op(REQ_STATUS, 4'd0, 32'sd0);         // nothing pending: delta at maximum
      send_op(REQ_POP, 4'd0, 32'sd0);            // pop with no live slot
      send_op(REQ_SCHEDULE, 4'd0, 32'sd10);
      send_op(REQ_SCHEDULE, 4'(NUM_EVENTS - 1), 32'sd10);   // same deadline, higher index
      send_op(REQ_SCHEDULE, 4'(NUM_EVENTS), 32'sd5);        // slot out of range: ignored
      send_op(REQ_CANCEL, 4'd15, 32'sd0);        // cancel out of range
      send_op(REQ_POP, 4'd0, 32'sd0);            // earliest deadline still ahead
      send_op(REQ_ADVANCE, 4'd0, 32'sd10);
      send_op(REQ_POP, 4'd0, 32'sd0);            // tie: lowest index goes first
      send_op(REQ_POP, 4'(NUM_EVENTS - 1), 32'sd0);
      send_op(REQ_SCHEDULE, 4'd3, AMT_MAX);
      send_op(REQ_ADVANCE, 4'd3, -32'sd1);       // distance beyond the clamp
      send_op(REQ_SCHEDULE, 4'd5, AMT_MIN);      // deadline far in the past
      send_op(REQ_POP, 4'd5, 32'sd0);            // pop moves time backwards
      send_op(REQ_STATUS, 4'd3, 32'sd0);
      send_op(REQ_CANCEL, 4'd3, 32'sd0);
      send_op(REQ_ADVANCE, 4'd0, AMT_MIN);
      send_op(REQ_ADVANCE, 4'd0, AMT_MAX);
      send_op(REQ_SPARE_FIRST, 4'd3, AMT_MAX);
      send_op(REQ_SPARE_LAST, 4'd9, AMT_MIN);
      send_op(REQ_SCHEDULE, 4'd1, 32'sd0);       // due right now
      send_op(REQ_POP, 4'd1, 32'sd0);
      send_op(REQ_STATUS, 4'(NUM_EVENTS), 32'sd0);
      send_op(REQ_SCHEDULE, 4'd6, -32'sd1);
      send_op(REQ_CANCEL, 4'd6, 32'sd0);
      wait_responses_drained();

      // Random part: mostly schedule, advance and pop so slots keep expiring.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = ((n / 150) % 4) == 2;
         if (n % 300 == 299) wait_responses_drained();

         roll = $urandom_range(99);
         if (roll < 30)      code = REQ_SCHEDULE;
         else if (roll < 50) code = REQ_ADVANCE;
         else if (roll < 75) code = REQ_POP;
         else if (roll < 85) code = REQ_CANCEL;
         else if (roll < 93) code = REQ_STATUS;
         else                code = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));

         if ($urandom_range(9) == 0) slot = 4'($urandom_range(15, NUM_EVENTS));
         else                        slot = 4'($urandom_range(NUM_EVENTS - 1));

         roll = $urandom_range(99);
         if (roll < 75) begin
            if (code == REQ_ADVANCE) amt = $urandom_range(40);
            else                     amt = $signed($urandom_range(90)) - 10;
         end else if (roll < 85) begin
            amt = $urandom;
         end else if (roll < 92) begin
            amt = AMT_MAX - $urandom_range(3);
         end else if (roll < 97) begin
            amt = AMT_MIN + $urandom_range(3);
         end else begin
            amt = -$signed($urandom_range(50));
         end

         send_op(code, slot, amt);
      end

      quiet = 1'b0;
      wait_responses_drained();
      repeat (POP_LATENCY + 8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
